// File: hdl/rsti_pkg.sv
// Shared types and constants for the radix string-to-integer converter.
package rsti_pkg;

   localparam int MAX_CHARS = 4096;
   localparam int POS_W     = $clog2(MAX_CHARS + 1);
   localparam int OFFSET_W  = 13;
   localparam int VALUE_W   = 64;
   localparam int CHAR_W    = 8;
   localparam int RADIX_W   = 6;
   localparam int DIGIT_W   = 6;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [POS_W-1:0]   MAX_POS = POS_W'(MAX_CHARS);

   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
   localparam logic [RADIX_W-1:0] BASE_MAX    = 6'd36;
   localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;
   localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
   localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;
   localparam logic [RADIX_W-1:0] BASE_BIN    = 6'd2;

   // Digit code for a character that is no digit in any base.
   localparam logic [DIGIT_W-1:0] NOT_DIGIT = 6'd63;

   localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
   localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
   localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
   localparam logic [CHAR_W-1:0] CH_UPPER_B = 8'h42;
   localparam logic [CHAR_W-1:0] CH_LOWER_B = 8'h62;

   // One classified character as it travels from the front to the back.
   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic               is_minus;
      logic               is_plus;
      logic               is_zero;
      logic               is_x;
      logic               is_b;
      logic               last;
   } item_type;

endpackage

// File: hdl/radix_string_to_integer.sv
// Top level of the radix string-to-integer converter.
// Characters of one string enter one item per cycle with req_last marking the final one;
// the sustained rate is one character per clock, set by the back stage (one multiply-by-base
// and add per cycle), while no final character waits on a full output register. A character
// passes the classify register, the four-entry queue and the parse stage; the result waits
// in an output register while new characters keep flowing. The radix register (reset 10,
// 0 for prefix detection) is written through the csr_ port, which is always ready; the user
// must write it only while no string is in flight, which the block does not enforce.
module radix_string_to_integer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rsti_pkg::RADIX_W-1:0]  csr_radix,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rsti_pkg::CHAR_W-1:0]   req_text_char,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [rsti_pkg::VALUE_W-1:0]  rsp_value,
   output logic [rsti_pkg::OFFSET_W-1:0] rsp_end_offset
);
   import rsti_pkg::*;

   logic     push_valid;
   logic     push_ready;
   item_type push_item;
   logic     pop_valid;
   logic     pop_ready;
   item_type pop_item;

   assign csr_ready = 1'b1;

   rsti_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_char (req_text_char),
      .req_last      (req_last),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_item     (push_item)
   );

   rsti_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   rsti_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_radix      (csr_radix),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_item       (pop_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (rsp_value),
      .rsp_end_offset (rsp_end_offset)
   );

endmodule

// File: hdl/rsti_front.sv
// Front stage: accepts characters and classifies them into digit values and marks.
module rsti_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [rsti_pkg::CHAR_W-1:0] req_text_char,
   input  logic                       req_last,
   output logic                       push_valid,
   input  logic                       push_ready,
   output rsti_pkg::item_type         push_item
);
   import rsti_pkg::*;

   logic     valid_ff;
   item_type item_ff;
   item_type item_in;
   logic [CHAR_W-1:0] diff;

   always_comb begin
      diff = '0;
      item_in.digit = NOT_DIGIT;
      if (req_text_char >= CH_ZERO && req_text_char <= CH_NINE) begin
         diff = req_text_char - CH_ZERO;
         item_in.digit = diff[DIGIT_W-1:0];
      end else if (req_text_char >= CH_UPPER_A && req_text_char <= CH_UPPER_Z) begin
         diff = req_text_char - CH_UPPER_A + CHAR_W'(BASE_DEC);
         item_in.digit = diff[DIGIT_W-1:0];
      end else if (req_text_char >= CH_LOWER_A && req_text_char <= CH_LOWER_Z) begin
         diff = req_text_char - CH_LOWER_A + CHAR_W'(BASE_DEC);
         item_in.digit = diff[DIGIT_W-1:0];
      end
      item_in.is_minus = (req_text_char == CH_MINUS);
      item_in.is_plus  = (req_text_char == CH_PLUS);
      item_in.is_zero  = (req_text_char == CH_ZERO);
      item_in.is_x     = (req_text_char == CH_UPPER_X) || (req_text_char == CH_LOWER_X);
      item_in.is_b     = (req_text_char == CH_UPPER_B) || (req_text_char == CH_LOWER_B);
      item_in.last     = req_last;
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;
   assign req_ready  = !valid_ff || push_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

// File: hdl/rsti_queue.sv
// Short queue of classified characters between the front and the back.
module rsti_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  rsti_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output rsti_pkg::item_type pop_item
);
   import rsti_pkg::*;

   item_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                do_push;
   logic                do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: hdl/rsti_back.sv
// Back stage: sign, prefix and digit parsing, radix register and result register.
module rsti_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [rsti_pkg::RADIX_W-1:0]  csr_radix,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  rsti_pkg::item_type            pop_item,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [rsti_pkg::VALUE_W-1:0]  rsp_value,
   output logic [rsti_pkg::OFFSET_W-1:0] rsp_end_offset
);
   import rsti_pkg::*;

   typedef enum logic [1:0] {
      PH_SIGN,
      PH_AUTO,
      PH_FIXED,
      PH_DIGITS
   } phase_type;

   logic [RADIX_W-1:0] radix_ff;
   phase_type          phase_ff,   phase_in;
   logic               negate_ff,  negate_in;
   logic [VALUE_W-1:0] acc_ff,     acc_in;
   logic [RADIX_W-1:0] base_ff,    base_in;
   logic [POS_W-1:0]   pos_ff,     pos_in;
   logic [POS_W-1:0]   stop_ff,    stop_in;
   logic               stopped_ff, stopped_in;

   logic               rsp_valid_ff;
   logic               rsp_neg_ff;
   logic [VALUE_W-1:0] rsp_acc_ff;
   logic [POS_W-1:0]   rsp_off_ff;

   logic               out_free;
   logic               take;
   logic               take_digit;
   logic [RADIX_W-1:0] take_base;
   logic [RADIX_W-1:0] radix_clip;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign pop_ready  = !pop_item.last || out_free;
   assign take       = pop_valid && pop_ready;
   assign radix_clip = (radix_ff > BASE_MAX) ? BASE_MAX : radix_ff;

   always_comb begin
      phase_in   = phase_ff;
      negate_in  = negate_ff;
      base_in    = base_ff;
      stop_in    = stop_ff;
      stopped_in = stopped_ff;
      pos_in     = (pos_ff < MAX_POS) ? pos_ff + 1'b1 : MAX_POS;
      take_digit = 1'b0;
      take_base  = base_ff;
      if (!stopped_ff) begin
         unique case (phase_ff)
            PH_SIGN: begin
               if (pop_item.is_minus) begin
                  negate_in = !negate_ff;
                  stop_in   = pos_in;
               end else if (pop_item.is_plus) begin
                  stop_in = pos_in;
               end else if (radix_ff == RADIX_AUTO) begin
                  if (pop_item.is_zero) begin
                     stop_in  = pos_in;
                     base_in  = BASE_OCT;
                     phase_in = PH_AUTO;
                  end else begin
                     base_in    = BASE_DEC;
                     phase_in   = PH_DIGITS;
                     take_digit = 1'b1;
                     take_base  = BASE_DEC;
                  end
               end else begin
                  base_in    = radix_clip;
                  take_digit = 1'b1;
                  take_base  = radix_clip;
                  // A possible 0x or 0b prefix waits for the next character.
                  if ((radix_clip == BASE_HEX || radix_clip == BASE_BIN)
                      && pop_item.is_zero && !pop_item.last) begin
                     phase_in = PH_FIXED;
                  end else begin
                     phase_in = PH_DIGITS;
                  end
               end
            end
            PH_AUTO: begin
               phase_in = PH_DIGITS;
               if (pop_item.is_x) begin
                  base_in = BASE_HEX;
                  stop_in = pos_in;
               end else if (pop_item.is_b) begin
                  base_in = BASE_BIN;
                  stop_in = pos_in;
               end else begin
                  base_in    = BASE_OCT;
                  take_digit = 1'b1;
                  take_base  = BASE_OCT;
               end
            end
            PH_FIXED: begin
               phase_in = PH_DIGITS;
               if ((base_ff == BASE_HEX && pop_item.is_x)
                   || (base_ff == BASE_BIN && pop_item.is_b)) begin
                  stop_in = pos_in;
               end else begin
                  take_digit = 1'b1;
               end
            end
            PH_DIGITS: begin
               take_digit = 1'b1;
            end
            default: begin
               phase_in = PH_SIGN;
            end
         endcase
      end
      acc_in = acc_ff;
      if (take_digit) begin
         if (pop_item.digit >= take_base) begin
            stopped_in = 1'b1;
         end else begin
            acc_in  = acc_ff * VALUE_W'(take_base) + VALUE_W'(pop_item.digit);
            stop_in = pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= RADIX_RESET;
         phase_ff     <= PH_SIGN;
         negate_ff    <= 1'b0;
         acc_ff       <= '0;
         base_ff      <= '0;
         pos_ff       <= '0;
         stop_ff      <= '0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            radix_ff <= csr_radix;
         end
         if (take && pop_item.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (take) begin
            if (pop_item.last) begin
               // The string ends: hand over the result and start the next one clean.
               rsp_neg_ff   <= negate_in;
               rsp_acc_ff   <= acc_in;
               rsp_off_ff   <= stop_in;
               phase_ff     <= PH_SIGN;
               negate_ff    <= 1'b0;
               acc_ff       <= '0;
               base_ff      <= '0;
               pos_ff       <= '0;
               stop_ff      <= '0;
               stopped_ff   <= 1'b0;
            end else begin
               phase_ff   <= phase_in;
               negate_ff  <= negate_in;
               acc_ff     <= acc_in;
               base_ff    <= base_in;
               pos_ff     <= pos_in;
               stop_ff    <= stop_in;
               stopped_ff <= stopped_in;
            end
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = $signed(rsp_neg_ff ? ('0 - rsp_acc_ff) : rsp_acc_ff);
   assign rsp_end_offset = OFFSET_W'(rsp_off_ff);

endmodule

// File: bench/tb.sv
// Self-checking testbench for the radix string-to-integer converter.
`timescale 1ns / 100ps

module tb;
   import rsti_pkg::*;

   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      logic [CHAR_W-1:0] text_char;
      logic              last;
   } char_item_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [OFFSET_W-1:0]       end_offset;
   } conversion_type;

   typedef enum logic [1:0] {SCAN_SIGN, AUTO_PREFIX, FIXED_PREFIX, DIGIT_RUN} parse_phase_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [RADIX_W-1:0]          csr_radix = RADIX_RESET;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [CHAR_W-1:0]           req_text_char = '0;
   logic                        req_last = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0]   rsp_value;
   logic [OFFSET_W-1:0]         rsp_end_offset;

   radix_string_to_integer u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_radix      (csr_radix),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_text_char  (req_text_char),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (rsp_value),
      .rsp_end_offset (rsp_end_offset)
   );

   char_item_type  char_queue[$];
   conversion_type expected_conversions[$];

   int chars_loaded = 0;
   int chars_offered = 0;
   int chars_taken = 0;
   int csr_writes = 0;
   int results_seen = 0;
   int error_count = 0;
   int stall_cycles = 0;
   int burst_left = 0;
   int gap_left = 0;
   int hold_left = 0;
   int ready_mode = 0;
   int mode_left = 0;
   bit squeeze_done = 1'b0;

   // Mirror of the converter state.
   logic [RADIX_W-1:0]  cfg_radix;
   parse_phase_type     conv_phase;
   logic                conv_negate;
   logic [VALUE_W-1:0]  conv_acc;
   logic [RADIX_W-1:0]  conv_base;
   logic [POS_W-1:0]    conv_pos;
   logic [POS_W-1:0]    conv_stop;
   logic                conv_stopped;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [DIGIT_W-1:0] digit_value(input logic [CHAR_W-1:0] ch);
      if (ch >= CH_ZERO && ch <= CH_NINE) return DIGIT_W'(ch - CH_ZERO);
      if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) return DIGIT_W'(ch - CH_UPPER_A + 10);
      if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) return DIGIT_W'(ch - CH_LOWER_A + 10);
      return NOT_DIGIT;
   endfunction

   task automatic clear_conversion();
      conv_phase   = SCAN_SIGN;
      conv_negate  = 1'b0;
      conv_acc     = '0;
      conv_base    = '0;
      conv_pos     = '0;
      conv_stop    = '0;
      conv_stopped = 1'b0;
   endtask

   task automatic accumulate_digit(input logic [CHAR_W-1:0] ch, input logic [POS_W-1:0] next_pos);
      logic [DIGIT_W-1:0] d;
      d = digit_value(ch);
      if (d >= conv_base) begin
         conv_stopped = 1'b1;
      end else begin
         conv_acc  = conv_acc * VALUE_W'(conv_base) + VALUE_W'(d);
         conv_stop = next_pos;
      end
   endtask

   // Advances the mirror by one character; a conversion is produced on the last one.
   task automatic convert_char(input logic [CHAR_W-1:0] ch, input logic fin,
                               output bit produced, output conversion_type conv);
      logic [POS_W-1:0] next_pos;
      logic             is_x, is_b;
      next_pos = (conv_pos < MAX_POS) ? conv_pos + 1'b1 : MAX_POS;
      is_x = (ch == CH_LOWER_X || ch == CH_UPPER_X);
      is_b = (ch == CH_LOWER_B || ch == CH_UPPER_B);
      if (!conv_stopped) begin
         case (conv_phase)
            SCAN_SIGN: begin
               if (ch == CH_MINUS) begin
                  conv_negate = ~conv_negate;
                  conv_stop   = next_pos;
               end else if (ch == CH_PLUS) begin
                  conv_stop = next_pos;
               end else if (cfg_radix == RADIX_AUTO) begin
                  if (ch == CH_ZERO) begin
                     conv_stop  = next_pos;
                     conv_base  = BASE_OCT;
                     conv_phase = AUTO_PREFIX;
                  end else begin
                     conv_base  = BASE_DEC;
                     conv_phase = DIGIT_RUN;
                     accumulate_digit(ch, next_pos);
                  end
               end else begin
                  conv_base = (cfg_radix > BASE_MAX) ? BASE_MAX : cfg_radix;
                  if ((conv_base == BASE_HEX || conv_base == BASE_BIN) && ch == CH_ZERO && !fin)
                     conv_phase = FIXED_PREFIX;
                  else
                     conv_phase = DIGIT_RUN;
                  accumulate_digit(ch, next_pos);
               end
            end
            AUTO_PREFIX: begin
               conv_phase = DIGIT_RUN;
               if (is_x) begin
                  conv_base = BASE_HEX;
                  conv_stop = next_pos;
               end else if (is_b) begin
                  conv_base = BASE_BIN;
                  conv_stop = next_pos;
               end else begin
                  conv_base = BASE_OCT;
                  accumulate_digit(ch, next_pos);
               end
            end
            FIXED_PREFIX: begin
               conv_phase = DIGIT_RUN;
               if ((conv_base == BASE_HEX && is_x) || (conv_base == BASE_BIN && is_b))
                  conv_stop = next_pos;
               else
                  accumulate_digit(ch, next_pos);
            end
            default: accumulate_digit(ch, next_pos);
         endcase
      end
      conv_pos = next_pos;
      produced = fin;
      conv.value = conv_negate ? -conv_acc : conv_acc;
      conv.end_offset = OFFSET_W'(conv_stop);
      if (fin) clear_conversion();
   endtask

   // Monitor: checks results, mirrors accepted characters and register writes.
   always @(posedge clock) begin : monitor
      conversion_type want, got;
      bit             produced;
      if (reset) begin
         cfg_radix = RADIX_RESET;
         clear_conversion();
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_conversions.size() == 0) begin
               if (error_count < 10)
                  $display("ERROR: result value=%0d offset=%0d with no string pending",
                           rsp_value, rsp_end_offset);
               error_count++;
            end else begin
               want = expected_conversions.pop_front();
               if (rsp_value !== want.value || rsp_end_offset !== want.end_offset) begin
                  if (error_count < 10)
                     $display("ERROR: value exp %0d got %0d, end_offset exp %0d got %0d",
                              want.value, rsp_value, want.end_offset, rsp_end_offset);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            convert_char(req_text_char, req_last, produced, got);
            if (produced) expected_conversions.push_back(got);
            chars_taken++;
         end
         if (csr_valid && csr_ready) begin
            cfg_radix = csr_radix;
            csr_writes++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Sender: bursts of characters separated by random gaps.
   always @(negedge clock) begin : sender
      char_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && chars_taken != chars_offered) begin
         // The current item has not been taken yet; keep it on the bus.
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left--;
      end else if (char_queue.size() != 0) begin
         item = char_queue.pop_front();
         req_valid     <= 1'b1;
         req_text_char <= item.text_char;
         req_last      <= item.last;
         chars_offered <= chars_offered + 1;
         if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 15);
         end else begin
            burst_left--;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver: switches among stall patterns, with occasional long hold-offs.
   always @(negedge clock) begin : receiver
      logic ready_next;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (!squeeze_done && results_seen >= 20 && chars_loaded - chars_offered >= 80) begin
         // Hold off long enough for the converter to fill up and stall its input.
         squeeze_done = 1'b1;
         hold_left = 400;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(10, 120);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            0:       ready_next = 1'b1;
            1:       ready_next = $urandom_range(0, 1);
            2:       ready_next = ($urandom_range(0, 3) == 0);
            default: ready_next = ~rsp_ready;
         endcase
         if ($urandom_range(0, 2999) == 0) begin
            hold_left  = $urandom_range(100, 400);
            ready_next = 1'b0;
         end
         rsp_ready <= ready_next;
      end
   end

   task automatic add_char(input logic [CHAR_W-1:0] ch, input logic fin);
      char_queue.push_back('{text_char: ch, last: fin});
      chars_loaded++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_char(CHAR_W'(s[i]), i == s.len() - 1);
   endtask

   // One string, mostly shaped for the radix: optional signs, prefix, digits and trailing junk; some are random bytes.
   task automatic add_random_string(input logic [RADIX_W-1:0] rdx);
      logic [CHAR_W-1:0] text[$];
      int unsigned       base, v;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 8)) text.push_back(CHAR_W'($urandom_range(0, 255)));
      end else begin
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3))
               text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
         base = (rdx > BASE_MAX) ? BASE_MAX : (rdx == RADIX_AUTO) ? BASE_DEC : rdx;
         if (rdx == RADIX_AUTO || rdx == BASE_HEX || rdx == BASE_BIN || $urandom_range(0, 3) == 0)
         begin
            case ($urandom_range(0, 3))
               0: begin
                  text.push_back(CH_ZERO);
                  text.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
                  if (rdx == RADIX_AUTO) base = BASE_HEX;
               end
               1: begin
                  text.push_back(CH_ZERO);
                  text.push_back($urandom_range(0, 1) ? CH_LOWER_B : CH_UPPER_B);
                  if (rdx == RADIX_AUTO) base = BASE_BIN;
               end
               2: begin
                  text.push_back(CH_ZERO);
                  if (rdx == RADIX_AUTO) base = BASE_OCT;
               end
               default: ;
            endcase
         end
         repeat ($urandom_range(0, 24)) begin
            if ($urandom_range(0, 15) == 0) begin
               text.push_back(CHAR_W'($urandom_range(0, 255)));
            end else begin
               v = $urandom_range(0, base - 1);
               if (v < 10)
                  text.push_back(CH_ZERO + CHAR_W'(v));
               else
                  text.push_back(($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + CHAR_W'(v - 10));
            end
         end
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) text.push_back(CHAR_W'($urandom_range(0, 255)));
      end
      if (text.size() == 0) text.push_back(CHAR_W'($urandom_range(0, 255)));
      foreach (text[i]) add_char(text[i], i == text.size() - 1);
   endtask

   task automatic add_random_strings(input logic [RADIX_W-1:0] rdx, input int count);
      int target;
      target = chars_loaded + count;
      while (chars_loaded < target) add_random_string(rdx);
   endtask

   // Returns at a falling edge once every character is taken and every result checked.
   task automatic wait_drained();
      do @(negedge clock);
      while (chars_taken != chars_loaded || expected_conversions.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   // Called at a falling edge; returns at the following rising edge after the write.
   task automatic write_radix(input logic [RADIX_W-1:0] value);
      int target;
      target = csr_writes + 1;
      csr_radix <= value;
      csr_valid <= 1'b1;
      do @(negedge clock);
      while (csr_writes != target);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      logic [RADIX_W-1:0] plan[$];
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset radix: sign runs, a sign-only string and the extreme byte values.
      add_text("--+42");
      add_text("-");
      add_char(8'hFF, 1'b1);
      add_char(CH_NINE, 1'b0);
      add_char(8'h00, 1'b1);
      add_random_strings(RADIX_RESET, 100);
      wait_drained();

      plan = '{RADIX_AUTO, BASE_HEX, BASE_BIN, RADIX_W'(1), BASE_MAX, RADIX_W'(63), BASE_OCT,
               RADIX_W'($urandom_range(3, 35)), RADIX_W'($urandom_range(37, 62)),
               RADIX_AUTO, BASE_DEC};
      foreach (plan[i]) begin
         write_radix(plan[i]);
         case (plan[i])
            RADIX_AUTO: begin
               add_text("0x1f");
               add_text("0B12");
               add_text("0");
               add_text("079");
            end
            BASE_HEX:     add_text("0x");
            RADIX_W'(1):  add_text("01");
            RADIX_W'(63): add_text("z");
            default: ;
         endcase
         add_random_strings(plan[i], 130);
         if (i == plan.size() - 1) begin
            // A string longer than MAX_CHARS, so the position and the end offset saturate at MAX_POS.
            add_char(CH_MINUS, 1'b0);
            for (int k = 0; k < 4110; k++)
               add_char(CH_ZERO + CHAR_W'($urandom_range(0, 9)), k == 4109);
         end
         wait_drained();
      end

      repeat (32) @(negedge clock);
      if (error_count == 0 && expected_conversions.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
